### rtl/stpq_pkg.sv
// ----------------------------------------------------------------------------
// stpq_pkg: shared types and constants of the sorted tag priority queue
// Item layouts, operation and status codes, the cell interface types and the
// sizing helpers for the membership reduction tree.
// ----------------------------------------------------------------------------
package stpq_pkg;

    // Field widths fixed by the item layout.
    localparam int TAG_BITS = 31;
    localparam int OCC_BITS = 7;

    // Default depth of the cell chain.
    localparam int DEF_CAPACITY = 64;

    // Fan-in of each stage of the membership reduction tree.
    localparam int OR_RADIX_LOG2 = 3;
    localparam int OR_RADIX      = 1 << OR_RADIX_LOG2;

    // Operation codes carried in the op field.
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_CHECK  = 2'd2;

    // Status codes carried in the status field.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    // Input item.
    typedef struct packed {
        logic [1:0]          op;
        logic [TAG_BITS-1:0] tag;
    } t_in_item;

    // Result item.
    typedef struct packed {
        logic                hit;
        logic [TAG_BITS-1:0] out_tag;
        logic [1:0]          status;
        logic [OCC_BITS-1:0] occupancy;
    } t_out_item;

    // One stored entry as handed between neighbouring cells.
    typedef struct packed {
        logic                valid;
        logic [TAG_BITS-1:0] tag;
    } t_entry;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic                ins;
        logic                pop;
        logic [TAG_BITS-1:0] tag;
    } t_cell_cmd;

    // Controller states.
    typedef enum logic {
        S_IDLE,
        S_CHECK
    } t_state;

    // Number of registered stages needed to reduce a vector of the given width.
    function automatic int tree_levels(input int width);
        int levels;
        int span;
        levels = 0;
        span   = 1;
        for (int k = 0; k < 16; k++) begin
            if (span < width) begin
                span   = span << OR_RADIX_LOG2;
                levels = levels + 1;
            end
        end
        return levels;
    endfunction

endpackage

### rtl/sorted_tag_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// sorted_tag_priority_queue_unit: sorted tag store with insert, pop and check
// A chain of cells keeps up to CAPACITY tags in ascending order.
//
// Usage: an item (op and tag) is taken at a rising edge with start high and
// busy low. Every item gives exactly one result, shown on o_result for one
// cycle with o_strobe high; the receiver cannot stall, so it must take each
// result in that cycle.
// Insert, pop and the unused op code give their result in the cycle after
// acceptance and leave busy low, so one such item can be taken every
// cycle; the chain shifts all cells in parallel.
// A check registers a match flag in every cell and then reduces them in a
// registered OR tree of tree_levels(CAPACITY) stages (two for 64 cells):
// busy is high while the flags pass through the tree, and the result is
// shown in the cycle in which busy falls; the next item can be taken at
// the edge ending that cycle.
// Reset (synchronous, active low) empties the store; there is no clearing
// pass, and no result is pending after reset.
// Occupancy is reported modulo 2**OCC_BITS.
// ----------------------------------------------------------------------------
module sorted_tag_priority_queue_unit
    import stpq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_item  i_item,
    output logic      busy,
    output logic      o_strobe,
    output t_out_item o_result
);

    localparam int CNT_BITS  = $clog2(CAPACITY + 1);
    localparam int LEVELS    = tree_levels(CAPACITY);
    localparam int WAIT_BITS = $clog2(LEVELS + 1);

    t_state               r_state, n_state;
    logic [WAIT_BITS-1:0] r_wait, n_wait;
    logic [CNT_BITS-1:0]  r_count, n_count;
    logic                 r_strobe, n_strobe;
    t_out_item            r_out, n_out;

    t_cell_cmd            w_cmd;
    t_entry               w_entry [CAPACITY];
    logic                 w_gt    [CAPACITY];
    logic [CAPACITY-1:0]  w_match;
    logic                 w_any;
    logic                 w_accept;
    logic                 w_full;
    logic                 w_empty;

    assign w_accept = start && (r_state == S_IDLE);
    assign w_full   = (r_count == CNT_BITS'(CAPACITY));
    assign w_empty  = (r_count == '0);

    // Command broadcast to the chain.
    assign w_cmd.ins = w_accept && (i_item.op == OP_INSERT) && !w_full;
    assign w_cmd.pop = w_accept && (i_item.op == OP_POP) && !w_empty;
    assign w_cmd.tag = i_item.tag;

    // The cell chain: each cell sees its two neighbours; the ends see empty slots.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        t_entry w_left;
        t_entry w_right;
        logic   w_left_gt;

        if (i == 0) begin : g_first
            assign w_left    = '0;
            assign w_left_gt = 1'b0;
        end else begin : g_inner_left
            assign w_left    = w_entry[i-1];
            assign w_left_gt = w_gt[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_inner_right
            assign w_right = w_entry[i+1];
        end

        stpq_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cmd     (w_cmd),
            .i_left    (w_left),
            .i_left_gt (w_left_gt),
            .i_right   (w_right),
            .o_entry   (w_entry[i]),
            .o_gt      (w_gt[i]),
            .o_match   (w_match[i])
        );
    end

    // Membership reduction over all cells.
    stpq_or_tree #(
        .WIDTH (CAPACITY)
    ) u_or_tree (
        .i_clk  (i_clk),
        .i_bits (w_match),
        .o_any  (w_any)
    );

    // Controller: next state, count and result.
    always_comb begin
        n_state  = r_state;
        n_wait   = r_wait;
        n_count  = r_count;
        n_strobe = 1'b0;
        n_out    = r_out;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_out.hit     = 1'b0;
                    n_out.out_tag = '0;
                    n_out.status  = STATUS_OK;
                    case (i_item.op)
                        OP_INSERT: begin
                            if (w_full) begin
                                n_out.status = STATUS_FULL;
                            end else begin
                                n_out.hit = 1'b1;
                                n_count   = r_count + 1'b1;
                            end
                            n_strobe = 1'b1;
                        end
                        OP_POP: begin
                            if (w_empty) begin
                                n_out.status = STATUS_EMPTY;
                            end else begin
                                n_out.hit     = 1'b1;
                                n_out.out_tag = w_entry[0].tag;
                                n_count       = r_count - 1'b1;
                            end
                            n_strobe = 1'b1;
                        end
                        OP_CHECK: begin
                            n_state = S_CHECK;
                            n_wait  = WAIT_BITS'(LEVELS);
                        end
                        default: begin
                            n_strobe = 1'b1;
                        end
                    endcase
                    n_out.occupancy = OCC_BITS'(n_count);
                end
            end
            S_CHECK: begin
                if (r_wait == '0) begin
                    n_out.hit       = w_any;
                    n_out.out_tag   = '0;
                    n_out.status    = STATUS_OK;
                    n_out.occupancy = OCC_BITS'(r_count);
                    n_strobe        = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    n_wait = r_wait - 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wait   <= '0;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wait   <= n_wait;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_out;

`ifndef NO_ASSERTIONS
    // Every item other than a check gives its result in the next cycle.
    a_fast_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_item.op != OP_CHECK)) |=> o_strobe)
        else $error("no result after an insert or pop");

    // No result is shown while a check is still in the reduction tree.
    a_check_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> !r_strobe)
        else $error("result shown during a check");

    // The count never exceeds the number of cells.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(CAPACITY))
        else $error("count beyond capacity");

    // The head cell is filled exactly when the store holds anything.
    a_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_entry[0].valid == (r_count != '0))
        else $error("head cell disagrees with count");
`endif

endmodule

### rtl/stpq_cell.sv
// ----------------------------------------------------------------------------
// stpq_cell: one slot of the sorted chain
// Holds one entry. On an insert it keeps its entry, takes the new tag or takes
// its left neighbour's entry; on a pop it takes its right neighbour's entry.
// ----------------------------------------------------------------------------
module stpq_cell
    import stpq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_cmd i_cmd,
    input  t_entry    i_left,
    input  logic      i_left_gt,
    input  t_entry    i_right,
    output t_entry    o_entry,
    output logic      o_gt,
    output logic      o_match
);

    logic                r_valid;
    logic [TAG_BITS-1:0] r_tag;
    logic                r_match;
    logic                n_valid;
    logic [TAG_BITS-1:0] n_tag;
    logic                w_gt;

    // An empty slot counts as greater, so the insert point is the first such slot.
    assign w_gt = !r_valid || (r_tag > i_cmd.tag);

    // Next entry: shift right from the insert point, or shift left on a pop.
    always_comb begin
        n_valid = r_valid;
        n_tag   = r_tag;
        if (i_cmd.ins && w_gt) begin
            if (i_left_gt) begin
                n_valid = i_left.valid;
                n_tag   = i_left.tag;
            end else begin
                n_valid = 1'b1;
                n_tag   = i_cmd.tag;
            end
        end else if (i_cmd.pop) begin
            n_valid = i_right.valid;
            n_tag   = i_right.tag;
        end
    end

    // The valid bit is control state; the tag needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Tag storage and the registered membership flag.
    always_ff @(posedge i_clk) begin
        r_tag   <= n_tag;
        r_match <= r_valid && (r_tag == i_cmd.tag);
    end

    assign o_entry.valid = r_valid;
    assign o_entry.tag   = r_tag;
    assign o_gt          = w_gt;
    assign o_match       = r_match;

endmodule

### rtl/stpq_or_tree.sv
// ----------------------------------------------------------------------------
// stpq_or_tree: registered OR reduction
// Reduces the per-cell match flags to one bit through stages of eight-input
// OR gates, one register stage per level.
// ----------------------------------------------------------------------------
module stpq_or_tree
    import stpq_pkg::*;
#(
    parameter int WIDTH = DEF_CAPACITY
)
(
    input  logic             i_clk,
    input  logic [WIDTH-1:0] i_bits,
    output logic             o_any
);

    localparam int LEVELS = tree_levels(WIDTH);
    localparam int PAD    = 1 << (LEVELS * OR_RADIX_LOG2);
    localparam int GROUPS = PAD / OR_RADIX;

    logic [PAD-1:0] w_src [LEVELS];
    logic [PAD-1:0] n_lvl [LEVELS];
    logic [PAD-1:0] r_lvl [LEVELS];

    // Inputs of each stage: the padded leaves, then the previous stage.
    always_comb begin
        w_src[0] = PAD'(i_bits);
        for (int l = 1; l < LEVELS; l++) begin
            w_src[l] = r_lvl[l-1];
        end
    end

    // Each stage ORs groups of eight bits; the upper part stays clear.
    always_comb begin
        for (int l = 0; l < LEVELS; l++) begin
            n_lvl[l] = '0;
            for (int j = 0; j < GROUPS; j++) begin
                n_lvl[l][j] = |w_src[l][j*OR_RADIX +: OR_RADIX];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lvl <= n_lvl;
    end

    assign o_any = r_lvl[LEVELS-1][0];

endmodule
